/* design/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cts_pkg.sv */
// package: types, constants and codes for the threshold sweep block
`default_nettype none
package cts_pkg;
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int THRESHOLD_COUNT_DEF = 21;
    localparam int SCORE_FULL = 10000;
    localparam int SCORE_W = 14;
    localparam int CNT_W = 11;
    localparam int Q_W = 17;
    localparam int PCT_W = 7;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_REPORT = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic               label;
        logic [SCORE_W-1:0] score;
    } t_in;

    typedef struct packed {
        logic [PCT_W-1:0] threshold_pct;
        logic [CNT_W-1:0] true_pos;
        logic [CNT_W-1:0] false_pos;
        logic [CNT_W-1:0] true_neg;
        logic [CNT_W-1:0] false_neg;
        logic [Q_W-1:0]   precision_q;
        logic [Q_W-1:0]   recall_q;
        logic [Q_W-1:0]   specificity_q;
        logic [Q_W-1:0]   fp_rate_q;
        logic [Q_W-1:0]   f1_q;
        logic [Q_W-1:0]   balanced_acc_q;
        logic             last;
    } t_out;

    // divider handshake between the sequencer and the divider
    typedef struct packed {
        logic            start;
        logic [CNT_W:0]  num;
        logic [CNT_W:0]  den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [Q_W-1:0]  quo;
    } t_div_rsp;
endpackage
`default_nettype wire

/* design/classifier_threshold_sweep.sv */
// Threshold sweep of a confusion matrix, one request at a time. An add request reads the
// bucket counter from a memory with a registered read and writes it back in the next
// cycle, with forwarding for back-to-back hits on the same bucket. A clear request sweeps
// both bucket memories; the same sweep runs after reset before the first request is taken.
// A report walks the buckets from the top down, then per threshold runs four serial
// divisions of 28 quotient steps each and presents the result, waiting for the output to
// be taken. The input waits while a clear or a report is in progress.
`default_nettype none
module classifier_threshold_sweep #(
    parameter int THRESHOLD_COUNT = cts_pkg::THRESHOLD_COUNT_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  cts_pkg::t_in  i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output cts_pkg::t_out o_data
);
    localparam int CW = cts_pkg::CNT_W;
    localparam int TW = 17;
    localparam int PW = cts_pkg::PCT_W;
    localparam int AW = $clog2(THRESHOLD_COUNT);
    localparam int TOP = THRESHOLD_COUNT - 1;
    localparam int RK = 28;
    localparam int MW = 22;
    localparam int BW = cts_pkg::SCORE_W + MW;
    localparam longint BMUL = ((longint'(TOP) << RK) + longint'(cts_pkg::SCORE_FULL - 1))
        / longint'(cts_pkg::SCORE_FULL);
    localparam int PCT_STEP = 100 / TOP;
    localparam int PCT_REM = 100 % TOP;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLR   = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_WAIT  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_RDK   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [CW:0]   mem_pos [THRESHOLD_COUNT];
    logic [CW:0]   mem_neg [THRESHOLD_COUNT];
    logic [CW:0]   r_rd_pos, r_rd_neg;
    logic [TW-1:0] r_total;
    logic          r_wr_en, r_wr_lab;
    logic [AW-1:0] r_wr_addr, r_addr;
    logic [AW-1:0] w_rd_addr, w_bucket;
    logic [CW:0]   w_cur_pos, w_cur_neg;
    logic [CW:0]   r_pos_all, r_neg_all, r_tp, r_fp;
    logic [AW-1:0] r_k;
    logic [PW-1:0] r_pct;
    logic [6:0]    r_pct_rem;
    logic [7:0]    w_pct_sum;
    logic [1:0]    r_dsel;
    logic [cts_pkg::Q_W-1:0] r_prec, r_rec, r_spec;
    logic          r_acc_pipe;
    cts_pkg::t_div_req w_req;
    cts_pkg::t_div_rsp w_rsp;
    logic [BW-1:0] w_mul;
    logic          w_take;

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign w_take  = i_valid && o_ready;

    // bucket = min(score,full)*TOP/full via a rounded-up reciprocal, exact over the score range
    always_comb begin
        logic [cts_pkg::SCORE_W-1:0] s;
        s = (i_data.score > cts_pkg::SCORE_W'(cts_pkg::SCORE_FULL))
            ? cts_pkg::SCORE_W'(cts_pkg::SCORE_FULL) : i_data.score;
        w_mul = BW'(s) * BW'(BMUL);
        w_bucket = w_mul[RK +: AW];
    end

    assign w_rd_addr = (r_state == S_IDLE) ? w_bucket : r_addr;

    // threshold percent steps by 100/TOP with the remainder carried
    assign w_pct_sum = {1'b0, r_pct_rem} + 8'(PCT_REM);

    // add: read at accept, write back next cycle; forward a hit on the same bucket
    logic r_hit_fwd;
    always_ff @(posedge i_clk) begin
        r_rd_pos <= mem_pos[w_rd_addr];
        r_rd_neg <= mem_neg[w_rd_addr];
        r_hit_fwd <= r_wr_en && (r_wr_addr == w_rd_addr);
        if (r_state == S_CLR) begin
            mem_pos[r_addr] <= '0;
            mem_neg[r_addr] <= '0;
        end else if (r_wr_en) begin
            if (r_wr_lab) mem_pos[r_wr_addr] <= w_cur_pos + 1'b1;
            else          mem_neg[r_wr_addr] <= w_cur_neg + 1'b1;
        end
    end

    logic [CW:0] r_fwd_pos, r_fwd_neg;
    always_ff @(posedge i_clk) begin
        r_fwd_pos <= w_cur_pos + (r_wr_lab ? 1'b1 : 1'b0);
        r_fwd_neg <= w_cur_neg + (r_wr_lab ? 1'b0 : 1'b1);
    end
    assign w_cur_pos = r_hit_fwd ? r_fwd_pos : r_rd_pos;
    assign w_cur_neg = r_hit_fwd ? r_fwd_neg : r_rd_neg;

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = '0;
        if (r_state == S_DIV) begin
            w_req.start = 1'b1;
            case (r_dsel)
                2'd0: begin w_req.num = r_tp; w_req.den = r_tp + r_fp; end
                2'd1: begin w_req.num = r_tp; w_req.den = r_pos_all; end
                2'd2: begin
                    w_req.num = r_neg_all - r_fp;
                    w_req.den = r_neg_all;
                end
                default: begin
                    w_req.num = {r_tp[CW-1:0], 1'b0};
                    w_req.den = {r_tp[CW-1:0], 1'b0} + r_fp + (r_pos_all - r_tp);
                end
            endcase
        end
    end

    cts_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_total <= '0;
            r_wr_en <= 1'b0;
            o_valid <= 1'b0;
            r_acc_pipe <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
                if (o_data.last) r_state <= S_IDLE;
                else begin
                    // bucket k drops out of the at-or-above sums for the next threshold
                    r_tp <= r_tp - w_cur_pos;
                    r_fp <= r_fp - w_cur_neg;
                    r_k <= r_k + 1'b1;
                    r_addr <= r_addr + 1'b1;
                    if (w_pct_sum >= 8'(TOP)) begin
                        r_pct_rem <= 7'(w_pct_sum - 8'(TOP));
                        r_pct <= r_pct + PW'(PCT_STEP + 1);
                    end else begin
                        r_pct_rem <= w_pct_sum[6:0];
                        r_pct <= r_pct + PW'(PCT_STEP);
                    end
                    r_state <= S_RDK;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        case (i_data.mode)
                            cts_pkg::MODE_ADD: begin
                                if (r_total < TW'(cts_pkg::MAX_SAMPLES_DEF)) begin
                                    r_wr_en   <= 1'b1;
                                    r_wr_addr <= w_bucket;
                                    r_wr_lab  <= i_data.label;
                                    r_total   <= r_total + 1'b1;
                                end
                            end
                            cts_pkg::MODE_CLEAR: begin
                                r_state <= S_CLR;
                                r_addr  <= '0;
                                r_total <= '0;
                            end
                            cts_pkg::MODE_REPORT: begin
                                r_state <= S_RD;
                                r_addr  <= AW'(TOP);
                                r_tp <= '0;
                                r_fp <= '0;
                                r_acc_pipe <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(TOP)) r_state <= S_IDLE;
                end
                S_RD: begin
                    // read top down; data appears next cycle
                    r_acc_pipe <= 1'b1;
                    if (r_acc_pipe) begin
                        r_tp <= r_tp + w_cur_pos;
                        r_fp <= r_fp + w_cur_neg;
                    end
                    if (r_addr == '0) r_state <= S_ACC;
                    else r_addr <= r_addr - 1'b1;
                end
                S_ACC: begin
                    // address stays at bucket 0, so its counts are on hand for the first step
                    r_tp <= r_tp + w_cur_pos;
                    r_fp <= r_fp + w_cur_neg;
                    r_pos_all <= r_tp + w_cur_pos;
                    r_neg_all <= r_fp + w_cur_neg;
                    r_k <= '0;
                    r_pct <= '0;
                    r_pct_rem <= '0;
                    r_state <= S_RDK;
                end
                S_RDK: begin
                    r_dsel <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_dsel <= r_dsel + 1'b1;
                        case (r_dsel)
                            2'd0: begin r_prec <= w_rsp.quo; r_state <= S_DIV; end
                            2'd1: begin r_rec  <= w_rsp.quo; r_state <= S_DIV; end
                            2'd2: begin r_spec <= w_rsp.quo; r_state <= S_DIV; end
                            default: begin
                                o_valid <= 1'b1;
                                o_data.threshold_pct <= r_pct;
                                o_data.true_pos  <= r_tp[CW-1:0];
                                o_data.false_pos <= r_fp[CW-1:0];
                                o_data.true_neg  <= CW'(r_neg_all - r_fp);
                                o_data.false_neg <= CW'(r_pos_all - r_tp);
                                o_data.precision_q <= r_prec;
                                o_data.recall_q    <= r_rec;
                                o_data.specificity_q <= r_spec;
                                o_data.fp_rate_q <= 17'd65536 - r_spec;
                                o_data.f1_q <= w_rsp.quo;
                                o_data.balanced_acc_q <= 17'((18'(r_rec) + 18'(r_spec)) >> 1);
                                o_data.last <= (r_k == AW'(TOP));
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: ;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `CTS_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready, "ready while busy")
    `CTS_ASSERT_IMP(a_total_cap, i_clk, i_rst_n, 1'b1, r_total <= TW'(cts_pkg::MAX_SAMPLES_DEF), "total over cap")
    `CTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
endmodule
`default_nettype wire

/* design/cts_div.sv */
// restoring divider: (num << 16) / den, one quotient bit per cycle, 0 on zero den
`default_nettype none
module cts_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  cts_pkg::t_div_req i_req,
    output cts_pkg::t_div_rsp o_rsp
);
    localparam int NW = cts_pkg::CNT_W + 1;
    localparam int QW = cts_pkg::Q_W;
    localparam int STEPS = NW + 16;

    logic [NW:0]      r_rem, n_rem;
    logic [NW-1:0]    r_den;
    logic [STEPS-1:0] r_shf, n_shf;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done, r_zero;
    logic [NW:0]      w_try;

    always_comb begin
        w_try = {r_rem[NW-1:0], r_shf[STEPS-1]};
        n_shf = {r_shf[STEPS-2:0], 1'b0};
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_shf[0] = 1'b1;
        end else begin
            n_rem = w_try;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_shf  <= {i_req.num, 16'd0};
                r_den  <= i_req.den;
                r_zero <= (i_req.den == '0);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_shf <= n_shf;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits collect in the low end of the shifter
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_zero ? '0 : r_shf[QW-1:0];

    `include "assert_macros.svh"
    `CTS_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_done, !r_busy, "divider busy after done")
    `CTS_ASSERT_IMP(a_div_start, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted")
endmodule
`default_nettype wire

/* tb/classifier_threshold_sweep_test.sv */
// testbench for classifier_threshold_sweep: directed and random samples, clears and reports checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module classifier_threshold_sweep_test;
    localparam int N_BUCKETS = cts_pkg::THRESHOLD_COUNT_DEF;
    localparam int CAPACITY = cts_pkg::MAX_SAMPLES_DEF;
    localparam int SCORE_FULL = cts_pkg::SCORE_FULL;
    localparam int PCT_W = cts_pkg::PCT_W;
    localparam int CNT_W = cts_pkg::CNT_W;
    localparam int Q_W = cts_pkg::Q_W;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    cts_pkg::t_in i_data;
    logic o_valid;
    logic i_ready;
    cts_pkg::t_out o_data;

    classifier_threshold_sweep i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    // predictor state
    int unsigned pos_cnt[N_BUCKETS];
    int unsigned neg_cnt[N_BUCKETS];
    int unsigned n_samples;

    cts_pkg::t_in pending_reqs[$];
    cts_pkg::t_out expected_rows[$];
    int errors = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cycles = 0;
    int rx_cycle = 0;
    int n_in_sent = 0;
    int n_in_taken = 0;
    int n_out_taken = 0;
    int n_out_seen = 0;

    function automatic longint unsigned q16(longint unsigned num, longint unsigned den);
        if (den == 0) return 0;
        return (num << 16) / den;
    endfunction

    task automatic clear_counts();
        for (int b = 0; b < N_BUCKETS; b++) begin
            pos_cnt[b] = 0;
            neg_cnt[b] = 0;
        end
        n_samples = 0;
    endtask

    task automatic predict_sweep(input cts_pkg::t_in req);
        longint unsigned sc, b, pos_all, neg_all, tp, fp, tn, fn, rec, spec;
        cts_pkg::t_out r;
        case (req.mode)
            cts_pkg::MODE_ADD: begin
                if (n_samples < CAPACITY) begin
                    sc = req.score;
                    if (sc > SCORE_FULL) sc = SCORE_FULL;
                    b = (sc * (N_BUCKETS - 1)) / SCORE_FULL;
                    if (req.label) pos_cnt[b]++;
                    else neg_cnt[b]++;
                    n_samples++;
                end
            end
            cts_pkg::MODE_CLEAR: clear_counts();
            cts_pkg::MODE_REPORT: begin
                pos_all = 0;
                neg_all = 0;
                for (int i = 0; i < N_BUCKETS; i++) begin
                    pos_all += pos_cnt[i];
                    neg_all += neg_cnt[i];
                end
                for (int k = 0; k < N_BUCKETS; k++) begin
                    tp = 0;
                    fp = 0;
                    for (int i = k; i < N_BUCKETS; i++) begin
                        tp += pos_cnt[i];
                        fp += neg_cnt[i];
                    end
                    fn = pos_all - tp;
                    tn = neg_all - fp;
                    rec = q16(tp, tp + fn);
                    spec = q16(tn, tn + fp);
                    r.threshold_pct = PCT_W'((k * 100) / (N_BUCKETS - 1));
                    r.true_pos = CNT_W'(tp);
                    r.false_pos = CNT_W'(fp);
                    r.true_neg = CNT_W'(tn);
                    r.false_neg = CNT_W'(fn);
                    r.precision_q = Q_W'(q16(tp, tp + fp));
                    r.recall_q = Q_W'(rec);
                    r.specificity_q = Q_W'(spec);
                    r.fp_rate_q = Q_W'(65536 - spec);
                    r.f1_q = Q_W'(q16(2 * tp, 2 * tp + fp + fn));
                    r.balanced_acc_q = Q_W'((rec + spec) >> 1);
                    r.last = (k == N_BUCKETS - 1);
                    expected_rows.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // driver: a request is held until the monitor has seen it taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            i_data <= '0;
        end else if (i_valid && n_in_taken != n_in_sent) begin
            // hold request until accepted
        end else begin
            if (i_valid) send_gap = $urandom_range(0, 11);
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_valid <= 0;
            end else begin
                i_data <= pending_reqs.pop_front();
                i_valid <= 1;
                n_in_sent++;
            end
        end
    end

    // receiver: a random gap (possibly none) after every taken result, and one long hold early on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 300) hold_cycles = 3000;
            if (n_out_taken != n_out_seen) begin
                n_out_seen = n_out_taken;
                recv_gap = $urandom_range(0, 11);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        cts_pkg::t_out exp_row;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_sweep(i_data);
                n_in_taken++;
            end
            if (o_valid && i_ready) begin
                n_out_taken++;
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display("%t unexpected result %p", $realtime, o_data);
                end else begin
                    exp_row = expected_rows.pop_front();
                    if (exp_row !== o_data) begin
                        errors++;
                        $display("%t mismatch expected %p actual %p", $realtime,
                            exp_row, o_data);
                    end
                end
            end
        end
    end

    function automatic cts_pkg::t_in mk(input logic [1:0] m, input logic l,
            input logic [13:0] s);
        cts_pkg::t_in r;
        r.mode = m;
        r.label = l;
        r.score = s;
        return r;
    endfunction

    initial begin
        int wait_cnt;
        int n;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty report, edges, saturation, ignored mode, clear
        pending_reqs.push_back(mk(cts_pkg::MODE_REPORT, 0, 0));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1, 0));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 0, 0));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1, 10000));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 0, 9999));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1, 14'h3fff));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 0, 10001));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1, 500));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 0, 499));
        pending_reqs.push_back(mk(cts_pkg::MODE_UNUSED, 1, 14'h2aaa));
        pending_reqs.push_back(mk(cts_pkg::MODE_UNUSED, 0, 14'h1555));
        pending_reqs.push_back(mk(cts_pkg::MODE_REPORT, 1, 14'h3fff));
        pending_reqs.push_back(mk(cts_pkg::MODE_CLEAR, 1, 14'h3fff));
        pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1, 5000));
        pending_reqs.push_back(mk(cts_pkg::MODE_REPORT, 0, 0));
        // only positives
        pending_reqs.push_back(mk(cts_pkg::MODE_CLEAR, 0, 0));
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1,
                14'($urandom_range(0, 10000))));
        pending_reqs.push_back(mk(cts_pkg::MODE_REPORT, 0, 0));

        // random: bursts of adds, with occasional clears and unused modes, each ending in a report
        n = 0;
        while (n < 85) begin
            if ($urandom_range(0, 5) == 0) begin
                pending_reqs.push_back(mk(cts_pkg::MODE_CLEAR, 1'($urandom), 14'($urandom)));
                n++;
            end
            repeat ($urandom_range(0, 12)) begin
                pending_reqs.push_back(mk(cts_pkg::MODE_ADD, 1'($urandom),
                    ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000))));
                n++;
            end
            if ($urandom_range(0, 6) == 0) begin
                pending_reqs.push_back(mk(cts_pkg::MODE_UNUSED, 1'($urandom), 14'($urandom)));
                n++;
            end
            pending_reqs.push_back(mk(cts_pkg::MODE_REPORT, 1'($urandom), 14'($urandom)));
            n++;
        end

        wait_cnt = 0;
        while ((pending_reqs.size() != 0 || i_valid || expected_rows.size() != 0)
                && wait_cnt < 2000000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (3000) @(posedge i_clk);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
